/* hw/rtl/spq_pkg.sv */
// spq_pkg: opcodes, status codes and sequencer states of the support point query block.
// No dependencies; imported by support_point_query.
package spq_pkg;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_status;

    localparam t_opcode OP_CLEAR  = 2'd0;
    localparam t_opcode OP_APPEND = 2'd1;
    localparam t_opcode OP_QUERY  = 2'd2;

    localparam t_status STS_OK    = 2'd0;
    localparam t_status STS_FULL  = 2'd1;
    localparam t_status STS_EMPTY = 2'd2;

    // width of the index field on the result channel
    localparam int INDEX_W = 8;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

endpackage

/* hw/rtl/spq_if.sv */
// spq_in_if / spq_out_if: valid/ready channels of the support point query block.
// Depends on nothing; coordinate and reach widths follow COORD_BITS.
interface spq_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, opcode, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, coord_z, output ready);
endinterface

interface spq_out_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic signed [COORD_BITS-1:0] best_x;
    logic signed [COORD_BITS-1:0] best_y;
    logic signed [COORD_BITS-1:0] best_z;
    logic [7:0]                   best_index;
    logic signed [2*COORD_BITS:0] reach;

    modport source (output valid, status, best_x, best_y, best_z, best_index, reach,
                    input ready);
    modport sink   (input valid, status, best_x, best_y, best_z, best_index, reach,
                    output ready);
endinterface

/* hw/rtl/spq_dot.sv */
// spq_dot: two-stage dot product unit (three products, then their sum).
// Standalone; used by support_point_query. Point and tag ride along with the data.
module spq_dot #(
    parameter int COORD_BITS = 16,
    parameter int TAG_W      = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [3*COORD_BITS-1:0]      i_point,
    input  logic signed [COORD_BITS-1:0] i_dir_x,
    input  logic signed [COORD_BITS-1:0] i_dir_y,
    input  logic signed [COORD_BITS-1:0] i_dir_z,
    input  logic [TAG_W-1:0]             i_tag,
    output logic                         o_valid,
    output logic [3*COORD_BITS-1:0]      o_point,
    output logic [TAG_W-1:0]             o_tag,
    output logic signed [2*COORD_BITS:0] o_sum
);
    localparam int CB     = COORD_BITS;
    localparam int PROD_W = 2 * CB;
    localparam int SUM_W  = 2 * CB + 1;

    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic signed [PROD_W-1:0] r_prod_z;
    logic [3*CB-1:0]          r_p_point;
    logic [TAG_W-1:0]         r_p_tag;

    logic                     r_s_valid;
    logic signed [SUM_W-1:0]  r_sum;
    logic [3*CB-1:0]          r_s_point;
    logic [TAG_W-1:0]         r_s_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
        end
    end

    // products: point layout is {x, y, z}
    always_ff @(posedge i_clk) begin
        r_prod_x  <= $signed(i_point[3*CB-1:2*CB]) * i_dir_x;
        r_prod_y  <= $signed(i_point[2*CB-1:CB])   * i_dir_y;
        r_prod_z  <= $signed(i_point[CB-1:0])      * i_dir_z;
        r_p_point <= i_point;
        r_p_tag   <= i_tag;
    end

    // exact sum; three products always fit in 2*CB+1 bits
    always_ff @(posedge i_clk) begin
        r_sum     <= SUM_W'(r_prod_x) + SUM_W'(r_prod_y) + SUM_W'(r_prod_z);
        r_s_point <= r_p_point;
        r_s_tag   <= r_p_tag;
    end

    assign o_valid = r_s_valid;
    assign o_point = r_s_point;
    assign o_tag   = r_s_tag;
    assign o_sum   = r_sum;

endmodule

/* hw/rtl/support_point_query.sv */
// support_point_query: point store with a max-dot-product (support point) query.
// Depends on spq_pkg, spq_if (spq_in_if, spq_out_if) and spq_dot.
//
// Usage:
//   Input channel i_in carries one command beat: opcode plus three signed
//   coordinates. Clear empties the store, append writes the point at the next
//   free index (status full and dropped when the store holds MAX_POINTS),
//   query treats the coordinates as a direction. Output channel o_out returns
//   exactly one result beat per command.
//   Latency: clear, append, unused opcode and query on an empty store give
//   their result one cycle after the command beat. A query over N stored
//   points reads one point per cycle from the store RAM into the shared
//   dot product unit; its last point goes through the RAM read register,
//   the product and sum stages of that unit and then the result register.
//   Throughput: one command at a time; a query keeps i_in.ready low until
//   its last point has left the dot product unit.
//   The block takes a new beat only when idle and the result register is
//   empty or being drained in the same cycle.
//   Reset: synchronous, active low; empties the store (count to zero) and
//   drops any pending result. Store contents are not cleared.
//   A stalled receiver holds the result in the output register and the
//   block stops taking commands until it is taken.
module support_point_query #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int CB      = COORD_BITS;
    localparam int PT_W    = 3 * CB;
    localparam int REACH_W = 2 * CB + 1;
    localparam int TAG_W   = 1 + IDX_W;

    // sequencer and store bookkeeping
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [IDX_W-1:0]   r_scan_addr;
    logic [IDX_W-1:0]   n_scan_addr;
    logic signed [CB-1:0] r_dir_x;
    logic signed [CB-1:0] r_dir_y;
    logic signed [CB-1:0] r_dir_z;

    // point RAM, one read port for the scan, one write port for appends
    logic [PT_W-1:0]    r_mem [MAX_POINTS];
    logic [PT_W-1:0]    r_rd_data;
    logic               r_rd_valid;
    logic               r_rd_last;
    logic [IDX_W-1:0]   r_rd_idx;

    // dot product unit outputs
    logic               d_valid;
    logic [PT_W-1:0]    d_point;
    logic [TAG_W-1:0]   d_tag;
    logic signed [REACH_W-1:0] d_sum;
    logic               d_last;
    logic [IDX_W-1:0]   d_idx;

    // running best
    logic [PT_W-1:0]    r_best_point;
    logic [IDX_W-1:0]   r_best_idx;
    logic signed [REACH_W-1:0] r_best_reach;
    logic [PT_W-1:0]    n_best_point;
    logic [IDX_W-1:0]   n_best_idx;
    logic signed [REACH_W-1:0] n_best_reach;
    logic               take;

    // result register
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_out_status;
    t_status            n_out_status;
    logic [PT_W-1:0]    r_out_point;
    logic [PT_W-1:0]    n_out_point;
    logic [INDEX_W-1:0] r_out_index;
    logic [INDEX_W-1:0] n_out_index;
    logic signed [REACH_W-1:0] r_out_reach;
    logic signed [REACH_W-1:0] n_out_reach;

    logic               in_fire;
    logic               out_free;
    logic               store_full;
    logic               do_write;
    logic               scan_last;
    logic [IDX_W+INDEX_W-1:0] best_idx_ext;

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign store_full  = (r_count == CNT_W'(MAX_POINTS));
    assign do_write    = in_fire && (i_in.opcode == OP_APPEND) && !store_full;
    assign scan_last   = (CNT_W'(r_scan_addr) + CNT_W'(1)) == r_count;

    // ---------------------------------------------------------------
    // Sequencer: IDLE takes commands, SCAN issues one RAM read per
    // cycle, FLUSH waits for the last point to leave the dot unit.
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan_addr = r_scan_addr;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in.opcode)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (!store_full) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            if (r_count != '0) begin
                                n_state     = S_SCAN;
                                n_scan_addr = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_scan_addr = r_scan_addr + IDX_W'(1);
                if (scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (d_valid && d_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan_addr <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_addr <= n_scan_addr;
            r_rd_valid  <= (r_state == S_SCAN);
        end
    end

    // direction is held for the whole scan
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dir_x <= i_in.coord_x;
            r_dir_y <= i_in.coord_y;
            r_dir_z <= i_in.coord_z;
        end
    end

    // point RAM
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_in.coord_x, i_in.coord_y, i_in.coord_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_rd_data <= r_mem[r_scan_addr];
            r_rd_idx  <= r_scan_addr;
            r_rd_last <= scan_last;
        end
    end

    // shared dot product unit
    spq_dot #(
        .COORD_BITS (COORD_BITS),
        .TAG_W      (TAG_W)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_point (r_rd_data),
        .i_dir_x (r_dir_x),
        .i_dir_y (r_dir_y),
        .i_dir_z (r_dir_z),
        .i_tag   ({r_rd_last, r_rd_idx}),
        .o_valid (d_valid),
        .o_point (d_point),
        .o_tag   (d_tag),
        .o_sum   (d_sum)
    );

    assign d_last = d_tag[TAG_W-1];
    assign d_idx  = d_tag[IDX_W-1:0];

    // ---------------------------------------------------------------
    // Compare: the first point always seeds the best; afterwards only a
    // strictly greater dot product replaces it, so ties keep the lower
    // index.
    // ---------------------------------------------------------------
    assign take = d_valid && ((d_idx == '0) || (d_sum > r_best_reach));

    always_comb begin
        n_best_point = r_best_point;
        n_best_idx   = r_best_idx;
        n_best_reach = r_best_reach;
        if (take) begin
            n_best_point = d_point;
            n_best_idx   = d_idx;
            n_best_reach = d_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_point <= n_best_point;
        r_best_idx   <= n_best_idx;
        r_best_reach <= n_best_reach;
    end

    assign best_idx_ext = {{INDEX_W{1'b0}}, n_best_idx};

    // ---------------------------------------------------------------
    // Result register: immediate results come from the command beat,
    // query results from the last point out of the dot unit.
    // ---------------------------------------------------------------
    always_comb begin
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_point  = r_out_point;
        n_out_index  = r_out_index;
        n_out_reach  = r_out_reach;
        if (in_fire) begin
            n_out_point = '0;
            n_out_index = '0;
            n_out_reach = '0;
            case (i_in.opcode)
                OP_APPEND: begin
                    n_out_valid  = 1'b1;
                    n_out_status = store_full ? STS_FULL : STS_OK;
                end
                OP_QUERY: begin
                    // non-empty query reports later from the scan
                    if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STS_EMPTY;
                    end
                end
                default: begin
                    // clear and the unused opcode
                    n_out_valid  = 1'b1;
                    n_out_status = STS_OK;
                end
            endcase
        end else if (d_valid && d_last) begin
            n_out_valid  = 1'b1;
            n_out_status = STS_OK;
            n_out_point  = n_best_point;
            n_out_index  = best_idx_ext[INDEX_W-1:0];
            n_out_reach  = n_best_reach;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_point  <= n_out_point;
        r_out_index  <= n_out_index;
        r_out_reach  <= n_out_reach;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.best_x     = r_out_point[3*CB-1:2*CB];
    assign o_out.best_y     = r_out_point[2*CB-1:CB];
    assign o_out.best_z     = r_out_point[CB-1:0];
    assign o_out.best_index = r_out_index;
    assign o_out.reach      = r_out_reach;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_valid && !d_valid))
        else $error("scan pipeline busy while idle");

    a_last_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_valid && d_last) |-> !r_out_valid)
        else $error("query result would overwrite a pending result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != STS_OK)) |->
            ((r_out_reach == '0) && (r_out_index == '0) && (r_out_point == '0)))
        else $error("failed command carries nonzero payload");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && scan_last) |=> (r_state == S_FLUSH))
        else $error("scan did not stop at the last stored point");

endmodule

/* tb/sv/tb_support_point_query.sv */
// tb_support_point_query: self-checking bench for the support point query block.
// Depends on spq_pkg, spq_in_if / spq_out_if and support_point_query.
// Predicts every result beat from its own copy of the point store and checks it on arrival.
module tb_support_point_query;
    import spq_pkg::*;

    localparam int MAX_POINTS    = 256;
    localparam int COORD_BITS    = 16;
    localparam int TRAFFIC_ITEMS = 750;
    // once this few commands are left, both sides run without gaps
    localparam int CALM_TAIL     = 100;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 400;
    // opcode the block ignores; not named in the package
    localparam t_opcode OP_UNUSED = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_opcode op;
        t_coord  cx;
        t_coord  cy;
        t_coord  cz;
    } t_cmd;

    typedef struct packed {
        t_status                     status;
        t_coord                      bx;
        t_coord                      by;
        t_coord                      bz;
        logic [INDEX_W-1:0]          idx;
        logic signed [2*COORD_BITS:0] reach;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  #(.COORD_BITS(COORD_BITS)) cmd_ch ();
    spq_out_if #(.COORD_BITS(COORD_BITS)) reply_ch ();

    support_point_query #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (reply_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // commands waiting to be offered, and replies predicted but not yet seen
    t_cmd   pending_cmds[$];
    t_reply predicted_replies[$];

    // mirror of the block's point store
    t_coord hull_x[MAX_POINTS];
    t_coord hull_y[MAX_POINTS];
    t_coord hull_z[MAX_POINTS];
    int     hull_count = 0;

    // fill level as seen by the stimulus builder, to steer well-formed sequences
    int     plan_count = 0;

    int     err_count  = 0;
    int     cmds_taken = 0;
    logic   cmd_fire   = 1'b0;
    logic   hold_off   = 1'b0;
    int     send_gap   = 0;
    int     sink_gap   = 0;

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return t_coord'(-32768);
            1: return t_coord'(32767);
            // small values make equal dot products, i.e. ties, likely
            2, 3: return t_coord'(int'($urandom_range(0, 8)) - 4);
            default: return t_coord'($urandom());
        endcase
    endfunction

    task automatic push_cmd(input t_opcode op, input t_coord x, input t_coord y,
                            input t_coord z);
        t_cmd c;
        c = '{op: op, cx: x, cy: y, cz: z};
        pending_cmds = {pending_cmds, c};
        if (op == OP_CLEAR) begin
            plan_count = 0;
        end else if (op == OP_APPEND && plan_count < MAX_POINTS) begin
            plan_count++;
        end
    endtask

    task automatic push_rand(input t_opcode op);
        push_cmd(op, rand_coord(), rand_coord(), rand_coord());
    endtask

    // Apply one accepted command to the mirrored store and queue the reply it gives.
    task automatic predict_support(input t_cmd c);
        t_reply r;
        longint best_dot;
        longint dot;
        int     best_i;
        r = '0;
        case (c.op)
            OP_CLEAR: begin
                hull_count = 0;
            end
            OP_APPEND: begin
                if (hull_count < MAX_POINTS) begin
                    hull_x[hull_count] = c.cx;
                    hull_y[hull_count] = c.cy;
                    hull_z[hull_count] = c.cz;
                    hull_count++;
                end else begin
                    r.status = STS_FULL;
                end
            end
            OP_QUERY: begin
                if (hull_count == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    best_i   = 0;
                    best_dot = longint'(hull_x[0]) * longint'(c.cx)
                             + longint'(hull_y[0]) * longint'(c.cy)
                             + longint'(hull_z[0]) * longint'(c.cz);
                    for (int i = 1; i < hull_count; i++) begin
                        dot = longint'(hull_x[i]) * longint'(c.cx)
                            + longint'(hull_y[i]) * longint'(c.cy)
                            + longint'(hull_z[i]) * longint'(c.cz);
                        // strictly greater only: lowest index wins a tie
                        if (dot > best_dot) begin
                            best_dot = dot;
                            best_i   = i;
                        end
                    end
                    r.status = STS_OK;
                    r.bx     = hull_x[best_i];
                    r.by     = hull_y[best_i];
                    r.bz     = hull_z[best_i];
                    r.idx    = best_i[INDEX_W-1:0];
                    r.reach  = best_dot[2*COORD_BITS:0];
                end
            end
            default: ;  // unused opcode: state untouched, all-zero reply
        endcase
        predicted_replies = {predicted_replies, r};
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Command side: sample acceptance at the rising edge and predict from it.
    always @(posedge i_clk) begin
        cmd_fire <= i_rst_n && cmd_ch.valid && cmd_ch.ready;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            predict_support('{op: cmd_ch.opcode, cx: cmd_ch.coord_x,
                              cy: cmd_ch.coord_y, cz: cmd_ch.coord_z});
            cmds_taken <= cmds_taken + 1;
        end
    end

    // Command driver: moves on the falling edge, only once the current beat is gone.
    always @(negedge i_clk) begin : drive_cmds
        t_cmd c;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                cmd_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
                // start a gap of random length, this one included
                send_gap = $urandom_range(0, 4);
                cmd_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                cmd_ch.opcode  <= c.op;
                cmd_ch.coord_x <= c.cx;
                cmd_ch.coord_y <= c.cy;
                cmd_ch.coord_z <= c.cz;
                cmd_ch.valid   <= 1'b1;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Reply side ready: random stalls, plus the long hold-off below.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            reply_ch.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            reply_ch.ready <= 1'b0;
        end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
            sink_gap = $urandom_range(0, 4);
            reply_ch.ready <= 1'b0;
        end else begin
            reply_ch.ready <= 1'b1;
        end
    end

    // Long receiver hold-off: the output register fills and the block
    // must push back on the command channel while the driver keeps offering.
    initial begin
        while (cmds_taken < HOLD_AFTER) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Reply checker: every accepted beat against the oldest prediction.
    always @(posedge i_clk) begin : check_replies
        t_reply w;
        if (i_rst_n && reply_ch.valid && reply_ch.ready) begin
            if (predicted_replies.size() == 0) begin
                err_count++;
                $display("%0t: reply beat with nothing predicted, expected none, actual status %0d",
                         $time, reply_ch.status);
            end else begin
                w = predicted_replies.pop_front();
                check_field("status", 64'(w.status), 64'(reply_ch.status));
                check_field("best_x", 64'(w.bx), 64'(reply_ch.best_x));
                check_field("best_y", 64'(w.by), 64'(reply_ch.best_y));
                check_field("best_z", 64'(w.bz), 64'(reply_ch.best_z));
                check_field("best_index", 64'(w.idx), 64'(reply_ch.best_index));
                check_field("reach", 64'(w.reach), 64'(reply_ch.reach));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int  k;
        int  pick;
        bit  filled;
        filled           = 1'b0;
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.opcode    = OP_CLEAR;
        cmd_ch.coord_x   = '0;
        cmd_ch.coord_y   = '0;
        cmd_ch.coord_z   = '0;
        reply_ch.ready   = 1'b0;

        // Directed: empty query, unused opcode, extremes, ties, zero direction.
        push_cmd(OP_QUERY, 0, 0, 0);
        push_rand(OP_UNUSED);
        push_cmd(OP_APPEND, -32768, -32768, -32768);
        push_cmd(OP_APPEND, 32767, 32767, 32767);
        push_cmd(OP_APPEND, -32768, -32768, -32768);   // same dot as index 0
        push_cmd(OP_APPEND, 0, 0, 0);
        push_cmd(OP_QUERY, -32768, -32768, -32768);    // largest reach, tie 0 vs 2
        push_cmd(OP_QUERY, 32767, 32767, 32767);
        push_cmd(OP_QUERY, 0, 0, 0);                   // all tie, index 0
        push_cmd(OP_QUERY, 32767, -32768, 0);
        push_cmd(OP_QUERY, -32768, 32767, 32767);
        push_rand(OP_UNUSED);
        push_cmd(OP_QUERY, 1, 0, 0);
        push_cmd(OP_CLEAR, -1, -1, -1);
        push_cmd(OP_QUERY, 5, 5, 5);                   // empty after clear
        push_cmd(OP_APPEND, -1, -1, -1);
        push_cmd(OP_QUERY, -1, -1, -1);
        push_cmd(OP_APPEND, 32767, -32768, 32767);
        push_cmd(OP_QUERY, -32768, 32767, -32768);     // index 0 wins over the large negative reach of index 1
        push_cmd(OP_CLEAR, 0, 0, 0);

        // Random: mostly clear / fill / query sequences, some noise,
        // and one pass that fills the store and overruns it.
        while (pending_cmds.size() < TRAFFIC_ITEMS) begin
            if (!filled && pending_cmds.size() > 350) begin
                filled = 1'b1;
                push_rand(OP_CLEAR);
                repeat (MAX_POINTS) push_rand(OP_APPEND);
                repeat (2) push_rand(OP_APPEND);       // dropped, store full
                repeat (2) push_rand(OP_QUERY);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    k = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
                    if (plan_count + k > MAX_POINTS || $urandom_range(0, 2) != 0) begin
                        push_rand(OP_CLEAR);
                    end
                    repeat (k) push_rand(OP_APPEND);
                    repeat ($urandom_range(1, 4)) push_rand(OP_QUERY);
                end else if (pick < 92) begin
                    push_rand(t_opcode'($urandom_range(0, 3)));
                end else begin
                    push_rand(OP_CLEAR);
                    push_rand(OP_QUERY);
                end
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || cmd_ch.valid) @(posedge i_clk);
        while (predicted_replies.size() > 0) @(posedge i_clk);
        // a full scan plus pipeline, so any stray beat still shows up
        repeat (MAX_POINTS + 8) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond a run of full-store queries with every stall.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
